>>> hdl/bisynch_reply_deframer_core_macros.svh
// Assertion macros shared by the deframer RTL.
// Included by the files that carry concurrent checks; needs no other file.
`ifndef BISYNCH_REPLY_DEFRAMER_CORE_MACROS_SVH
`define BISYNCH_REPLY_DEFRAMER_CORE_MACROS_SVH

`ifndef SYNTH
// Same-cycle implication, disabled while reset is asserted.
`define BRD_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
		else $error("deframer check failed");
// Next-cycle implication, disabled while reset is asserted.
`define BRD_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
		else $error("deframer check failed");
`else
`define BRD_ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define BRD_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

>>> hdl/brd_pkg.sv
// Types and constants of the reply deframer.
// No dependencies; imported by the interfaces and all modules.
package brd_pkg;

	localparam int unsigned BYTE_W   = 8;
	localparam int unsigned STATUS_W = 2;
	localparam int unsigned CFG_IDX_W = 2;

	localparam logic [BYTE_W-1:0] CHAR_EOT = 8'd4;
	localparam logic [BYTE_W-1:0] CHAR_ETX = 8'd3;
	localparam logic [BYTE_W-1:0] POS_MAX  = 8'd255;
	localparam logic [BYTE_W-1:0] POS_ECHO_FIRST  = 8'd1;
	localparam logic [BYTE_W-1:0] POS_ECHO_SECOND = 8'd2;
	localparam logic [BYTE_W-1:0] POS_DATA_FIRST  = 8'd3;

	localparam logic [BYTE_W-1:0] ECHO_FIRST_RESET  = 8'd80;
	localparam logic [BYTE_W-1:0] ECHO_SECOND_RESET = 8'd86;

	localparam logic [CFG_IDX_W-1:0] CFG_ECHO_FIRST  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ECHO_SECOND = 2'd1;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK          = 2'd0,
		ST_INVALID_REG = 2'd1,
		ST_CHECK_BAD   = 2'd2,
		ST_ECHO_BAD    = 2'd3
	} status_t;

	typedef struct packed {
		logic [BYTE_W-1:0] pos;
		logic [BYTE_W-1:0] chk;
		logic              echo_good;
		logic              etx_seen;
	} frame_state_t;

	typedef struct packed {
		logic [BYTE_W-1:0] data_char;
		status_t           frame_status;
		logic              is_last;
	} result_t;

	localparam frame_state_t FRAME_RESET = '{
		pos: '0, chk: '0, echo_good: 1'b1, etx_seen: 1'b0
	};

endpackage

>>> hdl/brd_ifs.sv
// Valid/ready channel interfaces for received bytes and deframer results.
// Depends on brd_pkg.
interface brd_in_if import brd_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface

interface brd_out_if import brd_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [BYTE_W-1:0]   data_char;
	logic [STATUS_W-1:0] frame_status;
	logic                is_last;

	modport source (output valid, output data_char, output frame_status, output is_last,
		input ready);
	modport sink   (input valid, input data_char, input frame_status, input is_last,
		output ready);
endinterface

>>> hdl/brd_step.sv
// Per-byte frame update: next frame state and the optional result item.
// Depends on brd_pkg.
module brd_step import brd_pkg::*; (
	input  frame_state_t      cur,
	input  logic [BYTE_W-1:0] rx_byte,
	input  logic [BYTE_W-1:0] echo_first,
	input  logic [BYTE_W-1:0] echo_second,
	output frame_state_t      nxt,
	output logic              emit,
	output result_t           res
);

	always_comb begin
		nxt  = cur;
		emit = 1'b0;
		res  = '{data_char: '0, frame_status: ST_OK, is_last: 1'b0};
		priority if (cur.etx_seen) begin
			// The byte after ETX is the block check; the check is reported before the echo.
			emit        = 1'b1;
			res.is_last = 1'b1;
			if (rx_byte != cur.chk) begin
				res.frame_status = ST_CHECK_BAD;
			end else if (!cur.echo_good) begin
				res.frame_status = ST_ECHO_BAD;
			end
			nxt = FRAME_RESET;
		end else if (cur.pos == '0 && rx_byte == CHAR_EOT) begin
			emit             = 1'b1;
			res.is_last      = 1'b1;
			res.frame_status = ST_INVALID_REG;
			nxt              = FRAME_RESET;
		end else begin
			if (cur.pos != '0) begin
				nxt.chk = cur.chk ^ rx_byte;
			end
			if (cur.pos != POS_MAX) begin
				nxt.pos = cur.pos + 1'b1;
			end
			if (rx_byte == CHAR_ETX) begin
				nxt.etx_seen = 1'b1;
				if (cur.pos < POS_DATA_FIRST) begin
					nxt.echo_good = 1'b0;
				end
			end else begin
				if (cur.pos == POS_ECHO_FIRST && rx_byte != echo_first) begin
					nxt.echo_good = 1'b0;
				end
				if (cur.pos == POS_ECHO_SECOND && rx_byte != echo_second) begin
					nxt.echo_good = 1'b0;
				end
				if (cur.pos >= POS_DATA_FIRST) begin
					emit          = 1'b1;
					res.data_char = rx_byte;
				end
			end
		end
	end

endmodule

>>> hdl/bisynch_reply_deframer_core.sv
// Reply deframer for block-check serial replies.
// Channels: in_ch carries one received byte per item; out_ch carries result
// items (a data character, or a final status with is_last set).
// Configuration: cfg_we writes cfg_wdata to register cfg_index (0 first echo
// character, 1 second echo character); other indexes are ignored.
// Each accepted byte is evaluated in the cycle it is accepted and its result,
// if any, appears on out_ch from the output register in the cycle after.
// Throughput is one byte per cycle: a new byte is taken whenever the output
// register is empty or its item is being taken in the same cycle.
// A byte that completes a frame (check byte or leading EOT) gives one status
// item and returns the frame state to its start.
// When the receiver stalls, the pending item holds and in_ch.ready drops
// until it is taken.
// Reset clears the frame state and the output valid flag and loads the
// echo characters with 'P' and 'V'.
// Depends on brd_pkg, brd_ifs, brd_step and the macros header.
`include "bisynch_reply_deframer_core_macros.svh"

module bisynch_reply_deframer_core import brd_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [BYTE_W-1:0]    cfg_wdata,
	brd_in_if.sink               in_ch,
	brd_out_if.source            out_ch
);

	logic [BYTE_W-1:0] echo_first_q;
	logic [BYTE_W-1:0] echo_second_q;
	frame_state_t      state_q;
	frame_state_t      state_nxt;
	logic              step_emit;
	result_t           step_res;
	logic              out_valid_q;
	result_t           out_q;
	logic              in_accept;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			echo_first_q  <= ECHO_FIRST_RESET;
			echo_second_q <= ECHO_SECOND_RESET;
		end else if (cfg_we) begin
			if (cfg_index == CFG_ECHO_FIRST) begin
				echo_first_q <= cfg_wdata;
			end
			if (cfg_index == CFG_ECHO_SECOND) begin
				echo_second_q <= cfg_wdata;
			end
		end
	end

	assign in_ch.ready = !out_valid_q || out_ch.ready;
	assign in_accept   = in_ch.valid && in_ch.ready;

	brd_step u_step (
		.cur         (state_q),
		.rx_byte     (in_ch.rx_byte),
		.echo_first  (echo_first_q),
		.echo_second (echo_second_q),
		.nxt         (state_nxt),
		.emit        (step_emit),
		.res         (step_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= FRAME_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (in_accept) begin
				state_q <= state_nxt;
			end
			if (in_accept && step_emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept && step_emit) begin
			out_q <= step_res;
		end
	end

	assign out_ch.valid        = out_valid_q;
	assign out_ch.data_char    = out_q.data_char;
	assign out_ch.frame_status = out_q.frame_status;
	assign out_ch.is_last      = out_q.is_last;

	// A status item never carries a character, and a data item is always ok.
	`BRD_ASSERT_IMPL(a_status_no_char, clk, arst_n, out_valid_q && out_q.is_last,
		out_q.data_char == '0)
	`BRD_ASSERT_IMPL(a_data_status_ok, clk, arst_n, out_valid_q && !out_q.is_last,
		out_q.frame_status == ST_OK)
	// ETX can only be flagged after at least one byte has been counted.
	`BRD_ASSERT_IMPL(a_etx_after_start, clk, arst_n, state_q.etx_seen, state_q.pos != '0)
	// A byte that ends the frame leaves the frame state at its start.
	`BRD_ASSERT_NEXT(a_frame_restart, clk, arst_n, in_accept && step_emit && step_res.is_last,
		state_q.pos == '0 && !state_q.etx_seen && state_q.echo_good && out_valid_q)

endmodule

>>> verif/tb_bisynch_reply_deframer_core.sv
`timescale 1ns / 1ps
// Self-checking testbench for bisynch_reply_deframer_core: random and directed reply frames,
// with a scoreboard class that predicts every data and status item.
// Depends on brd_pkg, brd_ifs and the deframer RTL.

module tb_bisynch_reply_deframer_core import brd_pkg::*; ();

	localparam int LIMIT_CYCLES = 400000;
	localparam int HOLD_OFF_CYCLES = 160;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

	typedef logic [BYTE_W-1:0] byte_q_t[$];

	// Predicts the reply deframer item by item and checks what comes out.
	class deframe_scoreboard;
		logic [BYTE_W-1:0] echo_first;
		logic [BYTE_W-1:0] echo_second;
		logic [BYTE_W-1:0] position;
		logic [BYTE_W-1:0] check_acc;
		bit                echo_ok;
		bit                after_etx;
		result_t           pending[$];
		int                errors;

		function new();
			echo_first = ECHO_FIRST_RESET;
			echo_second = ECHO_SECOND_RESET;
			errors = 0;
			clear_frame();
		endfunction

		function void clear_frame();
			position = '0;
			check_acc = '0;
			echo_ok = 1'b1;
			after_etx = 1'b0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [BYTE_W-1:0] value);
			if (idx == CFG_ECHO_FIRST)
				echo_first = value;
			else if (idx == CFG_ECHO_SECOND)
				echo_second = value;
		endfunction

		function void note_byte(logic [BYTE_W-1:0] b);
			result_t           r;
			logic [BYTE_W-1:0] pos_now;
			r.data_char = '0;
			r.frame_status = ST_OK;
			r.is_last = 1'b0;
			pos_now = position;
			if (after_etx) begin
				r.is_last = 1'b1;
				if (b != check_acc)
					r.frame_status = ST_CHECK_BAD;
				else if (!echo_ok)
					r.frame_status = ST_ECHO_BAD;
				pending.push_back(r);
				clear_frame();
				return;
			end
			if (pos_now == '0 && b == CHAR_EOT) begin
				r.is_last = 1'b1;
				r.frame_status = ST_INVALID_REG;
				pending.push_back(r);
				clear_frame();
				return;
			end
			// The start byte never enters the block check.
			if (pos_now >= POS_ECHO_FIRST)
				check_acc = check_acc ^ b;
			if (pos_now != POS_MAX)
				position = pos_now + 1'b1;
			if (b == CHAR_ETX) begin
				after_etx = 1'b1;
				if (pos_now < POS_DATA_FIRST)
					echo_ok = 1'b0;
				return;
			end
			if (pos_now == POS_ECHO_FIRST && b != echo_first)
				echo_ok = 1'b0;
			if (pos_now == POS_ECHO_SECOND && b != echo_second)
				echo_ok = 1'b0;
			if (pos_now >= POS_DATA_FIRST) begin
				r.data_char = b;
				pending.push_back(r);
			end
		endfunction

		function void flag(string what, int unsigned expd, int unsigned got);
			errors++;
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, expd, got);
		endfunction

		function void check_result(result_t got);
			result_t expd;
			if (pending.size() == 0) begin
				errors++;
				$display("%0t: unexpected item, expected none, actual char %0d status %0d last %0d",
					$time, got.data_char, got.frame_status, got.is_last);
				return;
			end
			expd = pending.pop_front();
			if (got.data_char !== expd.data_char)
				flag("data_char", 32'(expd.data_char), 32'(got.data_char));
			if (got.frame_status !== expd.frame_status)
				flag("frame_status", 32'(expd.frame_status), 32'(got.frame_status));
			if (got.is_last !== expd.is_last)
				flag("is_last", 32'(expd.is_last), 32'(got.is_last));
		endfunction

		function void report_leftover();
			if (pending.size() != 0) begin
				errors++;
				$display("%0t: items missing, expected %0d more, actual 0", $time, pending.size());
			end
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [BYTE_W-1:0]    cfg_wdata;

	brd_in_if  in_ch();
	brd_out_if out_ch();

	bisynch_reply_deframer_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.in_ch     (in_ch),
		.out_ch    (out_ch)
	);

	deframe_scoreboard sb;
	int tx_idle_pct;
	int rx_idle_pct;
	int hold_requests;
	int bytes_sent;
	int cycles;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > LIMIT_CYCLES) begin
				$display("tb_bisynch_reply_deframer_core: done, errors");
				$finish;
			end
		end
	end

	// Receiver: random stalls, plus a long hold-off each time one is requested.
	initial begin
		int hold_left;
		int holds_seen;
		hold_left = 0;
		holds_seen = 0;
		out_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_requests != holds_seen) begin
				holds_seen = hold_requests;
				hold_left = HOLD_OFF_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		result_t got;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			got.data_char = out_ch.data_char;
			got.frame_status = status_t'(out_ch.frame_status);
			got.is_last = out_ch.is_last;
			sb.check_result(got);
		end
	end

	task automatic send_byte(input logic [BYTE_W-1:0] b);
		while ($urandom_range(99) < tx_idle_pct) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.rx_byte <= b;
		@(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
		sb.note_byte(b);
		bytes_sent++;
	endtask

	task automatic send_frame(input logic [BYTE_W-1:0] start, input logic [BYTE_W-1:0] e1,
		input logic [BYTE_W-1:0] e2, input byte_q_t data, input bit break_check);
		logic [BYTE_W-1:0] bcc;
		bcc = e1 ^ e2 ^ CHAR_ETX;
		send_byte(start);
		send_byte(e1);
		send_byte(e2);
		foreach (data[i]) begin
			bcc = bcc ^ data[i];
			send_byte(data[i]);
		end
		send_byte(CHAR_ETX);
		if (break_check)
			bcc = bcc ^ BYTE_W'($urandom_range(1, 255));
		send_byte(bcc);
	endtask

	function automatic logic [BYTE_W-1:0] data_byte();
		logic [BYTE_W-1:0] b;
		do
			b = BYTE_W'($urandom_range(255));
		while (b == CHAR_ETX);
		return b;
	endfunction

	function automatic byte_q_t data_block(input int len);
		byte_q_t q;
		repeat (len)
			q.push_back(data_byte());
		return q;
	endfunction

	task automatic send_random_frame();
		int                kind;
		int                len;
		logic [BYTE_W-1:0] start;
		logic [BYTE_W-1:0] e1;
		logic [BYTE_W-1:0] e2;
		kind = $urandom_range(99);
		if (kind < 70) begin
			do
				start = BYTE_W'($urandom_range(255));
			while (start == CHAR_EOT || start == CHAR_ETX);
			e1 = ($urandom_range(99) < 85) ? sb.echo_first : BYTE_W'($urandom_range(255));
			e2 = ($urandom_range(99) < 85) ? sb.echo_second : BYTE_W'($urandom_range(255));
			len = ($urandom_range(9) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
			send_frame(start, e1, e2, data_block(len), $urandom_range(99) < 15);
		end else if (kind < 80) begin
			send_byte(CHAR_EOT);
		end else if (kind < 90) begin
			// Broken frame: ETX before the data part starts.
			repeat ($urandom_range(0, 2))
				send_byte(data_byte());
			send_byte(CHAR_ETX);
			send_byte(BYTE_W'($urandom_range(255)));
		end else begin
			repeat ($urandom_range(1, 6))
				send_byte(BYTE_W'($urandom_range(255)));
		end
	endtask

	task automatic run_random(input int n_items);
		int stop_at;
		stop_at = bytes_sent + n_items;
		while (bytes_sent < stop_at)
			send_random_frame();
	endtask

	task automatic wait_for_results();
		in_ch.valid <= 1'b0;
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
		input logic [BYTE_W-1:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		@(posedge clk);
		sb.write_reg(idx, value);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	initial begin
		byte_q_t none;
		byte_q_t extremes;
		sb = new();
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		hold_requests = 0;
		bytes_sent = 0;
		arst_n = 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= CFG_ECHO_FIRST;
		cfg_wdata <= '0;
		in_ch.valid <= 1'b0;
		in_ch.rx_byte <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Directed frames against the reset echo characters.
		extremes.push_back(8'h00);
		extremes.push_back(8'hFF);
		send_byte(CHAR_EOT);
		send_frame(8'h02, ECHO_FIRST_RESET, ECHO_SECOND_RESET, extremes, 1'b0);
		send_frame(8'hFF, ECHO_FIRST_RESET, ECHO_SECOND_RESET, none, 1'b1);
		send_frame(8'h00, 8'h58, ECHO_SECOND_RESET, none, 1'b0);
		// Bad echo and bad check together must report the check.
		send_frame(8'h01, ECHO_FIRST_RESET, 8'h00, none, 1'b1);
		// ETX as the very first byte leaves the check at zero.
		send_byte(CHAR_ETX);
		send_byte(8'h00);
		send_byte(8'h02);
		send_byte(ECHO_FIRST_RESET);
		send_byte(CHAR_ETX);
		send_byte(ECHO_FIRST_RESET ^ CHAR_ETX);
		wait_for_results();

		write_register(CFG_SPARE_A, BYTE_W'($urandom_range(255)));
		write_register(CFG_SPARE_B, BYTE_W'($urandom_range(255)));
		write_register(CFG_ECHO_FIRST, 8'h00);
		write_register(CFG_ECHO_SECOND, 8'hFF);
		tx_idle_pct = 30;
		rx_idle_pct = 46;
		run_random(560);
		wait_for_results();

		write_register(CFG_ECHO_FIRST, 8'hFF);
		write_register(CFG_ECHO_SECOND, 8'h00);
		tx_idle_pct = 46;
		rx_idle_pct = 30;
		run_random(560);
		wait_for_results();

		write_register(CFG_ECHO_FIRST, BYTE_W'($urandom_range(255)));
		write_register(CFG_ECHO_SECOND, BYTE_W'($urandom_range(255)));
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		// A long frame runs the position count into saturation while the
		// receiver holds off and the input side backs up.
		hold_requests++;
		send_frame(8'h02, sb.echo_first, sb.echo_second, data_block(300), 1'b0);
		run_random(300);
		wait_for_results();

		sb.report_leftover();
		if (sb.errors == 0)
			$display("tb_bisynch_reply_deframer_core: done, clean");
		else
			$display("tb_bisynch_reply_deframer_core: done, errors");
		$finish;
	end

endmodule
